// ===== rtl/pedal_to_torque_map_defines.svh =====
// assertion macros shared by the pedal to torque map checker
`ifndef PEDAL_TO_TORQUE_MAP_DEFINES_SVH
`define PEDAL_TO_TORQUE_MAP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PTM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PTM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ptm_pkg.sv =====
// types and constants of the pedal to torque map
`default_nettype none
package ptm_pkg;

  localparam int PEDAL_BITS_DEF  = 17;
  localparam int TORQUE_BITS_DEF = 16;
  localparam int CFG_IDX_BITS    = 3;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);

  // register reset values
  localparam int RST_ERROR_BELOW    = 0;
  localparam int RST_REGEN_FULL_TOP = 1638;
  localparam int RST_REGEN_RAMP_TOP = 3277;
  localparam int RST_COAST_TOP      = 4915;
  localparam int RST_ACCEL_RAMP_TOP = 14746;
  localparam int RST_PEDAL_TOP      = 16384;
  localparam int RST_REGEN_TORQUE   = 0;
  localparam int RST_DRIVE_LIMIT    = 0;

  typedef enum logic [2:0] {
    ZONE_ERROR      = 3'd0,
    ZONE_REGEN_FULL = 3'd1,
    ZONE_REGEN_RAMP = 3'd2,
    ZONE_COAST      = 3'd3,
    ZONE_ACCEL_RAMP = 3'd4,
    ZONE_ACCEL_FULL = 3'd5
  } zone_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ERROR_BELOW    = 3'd0,
    REG_REGEN_FULL_TOP = 3'd1,
    REG_REGEN_RAMP_TOP = 3'd2,
    REG_COAST_TOP      = 3'd3,
    REG_ACCEL_RAMP_TOP = 3'd4,
    REG_PEDAL_TOP      = 3'd5,
    REG_REGEN_TORQUE   = 3'd6,
    REG_DRIVE_LIMIT    = 3'd7
  } cfg_reg_t;

  // per-word control carried from classifier to divider
  typedef struct packed {
    logic  neg;
    zone_t zone;
  } ptm_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/ptm_front.sv =====
// classifier: sorts a pedal word into its zone and sets up the ramp fraction
`default_nettype none
module ptm_front #(
  parameter int PW = 17,
  parameter int TW = 16
) (
  input  logic signed [PW-1:0] pedal,
  input  logic signed [PW-1:0] err_lo,
  input  logic signed [PW-1:0] rf_top,
  input  logic signed [PW-1:0] rr_top,
  input  logic signed [PW-1:0] co_top,
  input  logic signed [PW-1:0] ar_top,
  input  logic signed [PW-1:0] pd_top,
  input  logic signed [TW-1:0] regen,
  input  logic signed [TW-1:0] drive,
  output ptm_pkg::ptm_ctrl_t   ctrl,
  output logic [PW-1:0]        num,
  output logic [PW-1:0]        den,
  output logic [TW-1:0]        mag
);
  import ptm_pkg::*;

  logic signed [PW:0]   d_rr_p;
  logic signed [PW:0]   d_rr_rf;
  logic signed [PW:0]   d_p_co;
  logic signed [PW:0]   d_ar_co;
  logic signed [TW-1:0] lim;
  logic [TW-1:0]        lim_abs;
  zone_t                zone;

  // differences fit PW bits unsigned when the zone that uses them is hit
  assign d_rr_p  = {rr_top[PW-1], rr_top} - {pedal[PW-1], pedal};
  assign d_rr_rf = {rr_top[PW-1], rr_top} - {rf_top[PW-1], rf_top};
  assign d_p_co  = {pedal[PW-1], pedal} - {co_top[PW-1], co_top};
  assign d_ar_co = {ar_top[PW-1], ar_top} - {co_top[PW-1], co_top};

  always_comb begin
    if (pedal < err_lo) begin
      zone = ZONE_ERROR;
    end else if (pedal <= rf_top) begin
      zone = ZONE_REGEN_FULL;
    end else if (pedal <= rr_top) begin
      zone = ZONE_REGEN_RAMP;
    end else if (pedal <= co_top) begin
      zone = ZONE_COAST;
    end else if (pedal <= ar_top) begin
      zone = ZONE_ACCEL_RAMP;
    end else if (pedal <= pd_top) begin
      zone = ZONE_ACCEL_FULL;
    end else begin
      zone = ZONE_ERROR;
    end
  end

  assign lim     = (zone == ZONE_REGEN_FULL || zone == ZONE_REGEN_RAMP) ? regen : drive;
  assign lim_abs = lim[TW-1] ? (~lim + TW'(1)) : lim;

  // full zones run through the divider as 1/1, dead zones as 0/1
  always_comb begin
    num       = PW'(1);
    den       = PW'(1);
    mag       = lim_abs;
    ctrl.neg  = lim[TW-1];
    ctrl.zone = zone;
    unique case (zone)
      ZONE_REGEN_RAMP: begin
        num = d_rr_p[PW-1:0];
        den = d_rr_rf[PW-1:0];
      end
      ZONE_ACCEL_RAMP: begin
        num = d_p_co[PW-1:0];
        den = d_ar_co[PW-1:0];
      end
      ZONE_REGEN_FULL, ZONE_ACCEL_FULL: begin
        num = PW'(1);
      end
      default: begin
        num      = '0;
        mag      = '0;
        ctrl.neg = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/ptm_queue.sv =====
// short first-in first-out queue between classifier and divider
`default_nettype none
module ptm_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         full,
  output logic         not_empty
);
  import ptm_pkg::*;

  logic [W-1:0]         entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QPTR_BITS'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QPTR_BITS'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = QCNT_BITS'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = QCNT_BITS'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ptm_back.sv =====
// multiply then restoring divide pipeline, one quotient bit a stage
`default_nettype none
module ptm_back #(
  parameter int PW = 17,
  parameter int TW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  ptm_pkg::ptm_ctrl_t   q_ctrl,
  input  logic [PW-1:0]        q_num,
  input  logic [PW-1:0]        q_den,
  input  logic [TW-1:0]        q_mag,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TW-1:0]        out_torque,
  output ptm_pkg::zone_t       out_zone
);
  import ptm_pkg::*;

  localparam int PR = PW + TW;

  logic              adv;
  logic [PR-1:0]     prod;

  // stage 0 holds the product split into its running remainder and low bits
  logic              vld_r  [TW+1];
  logic [PW-1:0]     rem_r  [TW+1];
  logic [TW-1:0]     low_r  [TW+1];
  logic [TW-1:0]     quo_r  [TW+1];
  logic [PW-1:0]     den_r  [TW+1];
  ptm_ctrl_t         ctrl_r [TW+1];

  logic              out_valid_r;
  logic [TW-1:0]     out_torque_r, out_torque_nxt;
  zone_t             out_zone_r;

  // the whole pipe moves unless a finished word waits at the output
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_valid;
  assign prod  = PR'(q_num) * PR'(q_mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= q_valid;
    end
  end

  // product < den * 2^TW, so the top PW bits already sit below den
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= prod[PR-1:TW];
      low_r[0]  <= prod[TW-1:0];
      quo_r[0]  <= '0;
      den_r[0]  <= q_den;
      ctrl_r[0] <= q_ctrl;
    end
  end

  for (genvar k = 1; k <= TW; k++) begin : g_div
    logic [PW:0]   trial;
    logic [PW:0]   diff;
    logic          take;
    logic [PW-1:0] rem_nxt;

    assign trial   = {rem_r[k-1], low_r[k-1][TW-1]};
    assign diff    = trial - {1'b0, den_r[k-1]};
    assign take    = (trial >= {1'b0, den_r[k-1]});
    assign rem_nxt = take ? diff[PW-1:0] : trial[PW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= rem_nxt;
        low_r[k]  <= {low_r[k-1][TW-2:0], 1'b0};
        quo_r[k]  <= {quo_r[k-1][TW-2:0], take};
        den_r[k]  <= den_r[k-1];
        ctrl_r[k] <= ctrl_r[k-1];
      end
    end
  end

  assign out_torque_nxt = ctrl_r[TW].neg ? (~quo_r[TW] + TW'(1)) : quo_r[TW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[TW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_torque_r <= out_torque_nxt;
      out_zone_r   <= ctrl_r[TW].zone;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_torque = out_torque_r;
  assign out_zone   = out_zone_r;

endmodule
`default_nettype wire

// ===== rtl/pedal_to_torque_map.sv =====
// Pedal to torque map. Each pedal word (signed Q2.14) is sorted into one of six
// zones by six thresholds tested in order, first match winning: error, full
// regen, regen ramp, coast, accel ramp, full accel; a pedal above pedal_top is
// an error. Error and coast give zero torque, the full zones give the regen or
// drive limit, the ramps give trunc(fraction * limit) with the fraction taken
// across the ramp. The classifier takes one word per clock into a four-entry
// queue while it is not full; behind it a multiplier and a TORQUE_BITS-stage
// restoring divider (one quotient bit per stage) also take one word per clock
// while the output is not stalled, a sustained rate of one word per cycle. The
// user must write registers through cfg_wen/cfg_addr/cfg_wdata only while the
// block is idle; the block itself does not enforce this.
`default_nettype none
module pedal_to_torque_map #(
  parameter int PEDAL_BITS  = ptm_pkg::PEDAL_BITS_DEF,
  parameter int TORQUE_BITS = ptm_pkg::TORQUE_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // pedal_position
  input  logic [((PEDAL_BITS+7)/8)*8-1:0]            in_tdata,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // torque_out
  output logic [((TORQUE_BITS+7)/8)*8-1:0]           out_tdata,
  // zone
  output logic [2:0]                                 out_tuser,
  input  logic                                       cfg_wen,
  input  logic [ptm_pkg::CFG_IDX_BITS-1:0]           cfg_addr,
  input  logic [((PEDAL_BITS > TORQUE_BITS) ? PEDAL_BITS : TORQUE_BITS)-1:0] cfg_wdata
);
  import ptm_pkg::*;

  localparam int PW    = PEDAL_BITS;
  localparam int TW    = TORQUE_BITS;
  localparam int OUT_W = ((TW + 7) / 8) * 8;
  localparam int QW    = $bits(ptm_ctrl_t) + TW + 2 * PW;

  logic signed [PW-1:0] err_lo_r, rf_top_r, rr_top_r, co_top_r, ar_top_r, pd_top_r;
  logic signed [TW-1:0] regen_r, drive_r;

  ptm_ctrl_t     f_ctrl, h_ctrl;
  logic [PW-1:0] f_num, f_den, h_num, h_den;
  logic [TW-1:0] f_mag, h_mag;
  logic [QW-1:0] q_head;
  logic          q_full, q_not_empty, q_pop, push;
  logic [TW-1:0] torque;
  zone_t         zone;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_lo_r <= PW'(RST_ERROR_BELOW);
      rf_top_r <= PW'(RST_REGEN_FULL_TOP);
      rr_top_r <= PW'(RST_REGEN_RAMP_TOP);
      co_top_r <= PW'(RST_COAST_TOP);
      ar_top_r <= PW'(RST_ACCEL_RAMP_TOP);
      pd_top_r <= PW'(RST_PEDAL_TOP);
      regen_r  <= TW'(RST_REGEN_TORQUE);
      drive_r  <= TW'(RST_DRIVE_LIMIT);
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ERROR_BELOW:    err_lo_r <= cfg_wdata[PW-1:0];
        REG_REGEN_FULL_TOP: rf_top_r <= cfg_wdata[PW-1:0];
        REG_REGEN_RAMP_TOP: rr_top_r <= cfg_wdata[PW-1:0];
        REG_COAST_TOP:      co_top_r <= cfg_wdata[PW-1:0];
        REG_ACCEL_RAMP_TOP: ar_top_r <= cfg_wdata[PW-1:0];
        REG_PEDAL_TOP:      pd_top_r <= cfg_wdata[PW-1:0];
        REG_REGEN_TORQUE:   regen_r  <= cfg_wdata[TW-1:0];
        REG_DRIVE_LIMIT:    drive_r  <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  ptm_front #(.PW(PW), .TW(TW)) u_front (
    .pedal  (in_tdata[PW-1:0]),
    .err_lo (err_lo_r),
    .rf_top (rf_top_r),
    .rr_top (rr_top_r),
    .co_top (co_top_r),
    .ar_top (ar_top_r),
    .pd_top (pd_top_r),
    .regen  (regen_r),
    .drive  (drive_r),
    .ctrl   (f_ctrl),
    .num    (f_num),
    .den    (f_den),
    .mag    (f_mag)
  );

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  ptm_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_ctrl, f_mag, f_den, f_num}),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  assign {h_ctrl, h_mag, h_den, h_num} = q_head;

  ptm_back #(.PW(PW), .TW(TW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_ctrl     (h_ctrl),
    .q_num      (h_num),
    .q_den      (h_den),
    .q_mag      (h_mag),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_torque (torque),
    .out_zone   (zone)
  );

  assign out_tdata = OUT_W'(torque);
  assign out_tuser = zone;

endmodule
`default_nettype wire

// ===== rtl/ptm_checker.sv =====
// port-level checks of the pedal to torque map, bound to the top level
`default_nettype none
`include "pedal_to_torque_map_defines.svh"
module ptm_checker #(
  parameter int OUT_W = 16,
  parameter int TW    = 16
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata,
  input wire logic [2:0]       out_tuser
);
  import ptm_pkg::*;

  `PTM_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled output word changed")

  `PTM_ASSERT_IMP(a_rst_quiet, clk, rst_n, !$past(rst_n), !out_tvalid, "output valid straight after reset")

  `PTM_ASSERT_IMP(a_dead_zero, clk, rst_n, out_tvalid && (out_tuser == ZONE_ERROR || out_tuser == ZONE_COAST), out_tdata[TW-1:0] == '0, "error or coast zone with non-zero torque")

  `PTM_ASSERT_IMP(a_zone_range, clk, rst_n, out_tvalid, out_tuser <= ZONE_ACCEL_FULL, "zone code out of range")

  // the queue only fills behind a word that waits at the output
  `PTM_ASSERT_IMP(a_full_stall, clk, rst_n, in_tvalid && !in_tready, out_tvalid, "input stalled with no output word waiting")

endmodule

bind pedal_to_torque_map ptm_checker #(
  .OUT_W (((TORQUE_BITS + 7) / 8) * 8),
  .TW    (TORQUE_BITS)
) u_ptm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
